[hw/rtl/pts_pkg.sv]
// Shared types, constants and register codes for the periodic task scheduler.
package pts_pkg;

    // Channel count and datapath widths
    localparam int NUM_CH      = 4;
    localparam int PERIOD_REGS = 4;
    localparam int TIME_W      = 32;
    localparam int PERIOD_W    = 31;
    localparam int ACT_W       = 3;
    localparam int IDX_W       = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_ACTIVE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PERIOD0 = 3'd1;

    // Period reset values, one per period register
    localparam logic [PERIOD_W-1:0] PERIOD_RESET [PERIOD_REGS] =
        '{31'd1000, 31'd100, 31'd1000, 31'd1000};

    // What travels from one cell to the next with each request
    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] elapsed;
        logic [NUM_CH-1:0] mask;
    } pts_link_t;

endpackage

[hw/rtl/pts_cell.sv]
// One channel cell: holds a countdown and period, updates it as a request passes through.
module pts_cell
    import pts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // upstream side
    input  pts_link_t           link_i,
    output logic                take_o,
    // downstream side
    output pts_link_t           link_o,
    input  logic                take_i,
    // static per-cell settings
    input  logic                active,
    input  logic [NUM_CH-1:0]   fire_bit,
    input  logic [PERIOD_W-1:0] rst_period,
    // period register write
    input  logic                cfg_load,
    input  logic [PERIOD_W-1:0] cfg_period
);

    localparam int WIDE_W = TIME_W + 2;
    localparam logic signed [WIDE_W-1:0] SAT_MIN =
        -(WIDE_W'(1) <<< (TIME_W - 1));

    logic signed [TIME_W-1:0]   countdown_reg, countdown_next;
    logic        [PERIOD_W-1:0] period_reg;
    pts_link_t                  link_reg, link_next;

    logic signed [WIDE_W-1:0]   diff;
    logic signed [WIDE_W-1:0]   clamped;
    logic                       fire;
    logic                       advance;

    // Stage is free when empty or when its request moves on this cycle
    assign take_o  = !link_reg.valid || take_i;
    assign advance = link_i.valid && take_o;
    assign link_o  = link_reg;

    // Countdown minus elapsed, saturated, then one period added back on fire
    always_comb begin
        diff    = WIDE_W'(countdown_reg) - $signed({2'b00, link_i.elapsed});
        clamped = (diff < SAT_MIN) ? SAT_MIN : diff;
        fire    = active && (clamped <= 0);
        if (fire) begin
            countdown_next = TIME_W'(clamped + $signed({3'b000, period_reg}));
        end else begin
            countdown_next = TIME_W'(clamped);
        end
        link_next         = link_i;
        link_next.mask    = link_i.mask | (fire ? fire_bit : '0);
    end

    // Channel state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg    <= rst_period;
            countdown_reg <= $signed({1'b0, rst_period});
        end else if (cfg_load) begin
            period_reg    <= cfg_period;
            countdown_reg <= $signed({1'b0, cfg_period});
        end else if (advance && active) begin
            countdown_reg <= countdown_next;
        end
    end

    // Stage register toward the next cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_reg <= '0;
        end else if (take_o) begin
            link_reg <= link_next;
        end
    end

endmodule

[hw/rtl/periodic_task_scheduler_unit.sv]
// Top level of the periodic task scheduler: input stage, chain of channel cells, result port.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+--------------------------------------
//  s_      | in        | s_valid/s_ready  | s_now_ms[31:0]  timestamp in ms
//  m_      | out       | m_valid/m_ready  | m_fire_mask[3:0] channels that fired
//  cfg_    | in        | cfg_we           | cfg_index[2:0], cfg_data[30:0]
//
// One request is taken per cycle while the chain is not stalled; the input stage registers it
// at the accepting edge, then each channel cell's stage register passes it on to the result port.
// Each cell updates its own countdown as the request passes, so requests overlap freely.
// Reset is synchronous on aresetn low; periods and countdowns return to defaults.
// A stall on m_ready backs up stage by stage; empty stages still take requests.
module periodic_task_scheduler_unit
    import pts_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [TIME_W-1:0]   s_now_ms,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [NUM_CH-1:0]   m_fire_mask,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [PERIOD_W-1:0] cfg_data
);

    logic [ACT_W-1:0]  active_channels_reg;
    logic [TIME_W-1:0] last_time_reg;
    logic              in_valid_reg;
    logic [TIME_W-1:0] elapsed_reg;
    logic [NUM_CH-1:0] active_vec;

    pts_link_t         link [NUM_CH+1];
    logic              take [NUM_CH+1];

    logic              s_accept;

    assign s_ready  = !in_valid_reg || take[0];
    assign s_accept = s_valid && s_ready;

    // Active channel register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_channels_reg <= '0;
        end else if (cfg_we && cfg_index == REG_ACTIVE) begin
            active_channels_reg <= cfg_data[ACT_W-1:0];
        end
    end

    // Channel i is in use when below the active count (counts past NUM_CH clamp)
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            active_vec[i] = (32'(active_channels_reg) > i);
        end
    end

    // Input stage: elapsed time since previous request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            last_time_reg <= '0;
        end else if (s_accept) begin
            in_valid_reg  <= 1'b1;
            last_time_reg <= s_now_ms;
        end else if (take[0]) begin
            in_valid_reg  <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            elapsed_reg <= s_now_ms - last_time_reg;
        end
    end

    assign link[0] = '{valid: in_valid_reg, elapsed: elapsed_reg, mask: '0};

    // Chain of channel cells
    for (genvar g = 0; g < NUM_CH; g++) begin : g_cell
        pts_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .link_i     (link[g]),
            .take_o     (take[g]),
            .link_o     (link[g+1]),
            .take_i     (take[g+1]),
            .active     (active_vec[g]),
            .fire_bit   (NUM_CH'(1) << g),
            .rst_period (PERIOD_RESET[g]),
            .cfg_load   (cfg_we && cfg_index == IDX_W'(REG_PERIOD0 + g)),
            .cfg_period (cfg_data)
        );
    end

    // Result port is the last cell's stage register
    assign take[NUM_CH] = m_ready;
    assign m_valid      = link[NUM_CH].valid;
    assign m_fire_mask  = link[NUM_CH].mask;

    // Accepted request always occupies the input stage next cycle
    a_accept_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> in_valid_reg)
        else $error("accepted request did not enter input stage");

    // Stored timestamp tracks the last accepted request
    a_last_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> last_time_reg == $past(s_now_ms))
        else $error("last timestamp not updated on request");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !in_valid_reg)
        else $error("pipeline not empty after reset");

endmodule
